// ----- hdl/hpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types and constants of the homography point transform pipeline.
// ----------------------------------------------------------------------------
package hpt_pkg;

  localparam int CoordW   = 16;
  localparam int CoefW    = 32;
  localparam int NumRegs  = 8;
  localparam int ProdW    = CoefW + CoordW;
  localparam int AccW     = 50;
  localparam int QuotW    = 16;
  localparam int DivSteps = 16;

  localparam int RegH00 = 0;
  localparam int RegH01 = 1;
  localparam int RegH02 = 2;
  localparam int RegH10 = 3;
  localparam int RegH11 = 4;
  localparam int RegH12 = 5;
  localparam int RegH20 = 6;
  localparam int RegH21 = 7;

  localparam logic [CoefW-1:0] CoefOne = 32'h0100_0000;

  typedef logic [NumRegs-1:0][CoefW-1:0] coef_t;

  // identity matrix, h21 in the top word down to h00 in the bottom word
  localparam coef_t CoefReset = {32'h0, 32'h0, 32'h0, CoefOne,
                                 32'h0, 32'h0, 32'h0, CoefOne};

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatDivZero = 2'd1,
    StatSat     = 2'd2
  } status_e;

  // one coordinate under division
  typedef struct packed {
    logic [AccW-1:0]  rem;
    logic [QuotW-1:0] quot;
    logic             neg;
    logic             big;
  } chan_t;

  typedef struct packed {
    chan_t           cx;
    chan_t           cy;
    logic [AccW-1:0] den;
    logic            dz;
  } div_t;

endpackage

`default_nettype wire

// ----- hdl/homography_point_transform_unit.sv -----
// Pipeline from input transfer to result valid: 2 multiply/sum stages,
//   1 magnitude stage, 16 division steps, 1 round/saturate stage.
// Throughput: one point per cycle; a stalled output freezes the whole pipeline.
// Reset: asynchronous, active low; clears all valid bits and loads the
//   identity matrix.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// homography_point_transform_unit
// Maps Q12.4 points through a configured 3x3 perspective matrix.
// ----------------------------------------------------------------------------
module homography_point_transform_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // in_x[15:0], in_y[31:16]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // out_x[15:0], out_y[31:16], status[33:32]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  hpt_pkg::coef_t coef_q;
  logic           adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= hpt_pkg::CoefReset;
    end else if (psel && penable && pwrite) begin
      coef_q[paddr[4:2]] <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = coef_q[paddr[4:2]];

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic                           mac_vld;
  logic signed [hpt_pkg::AccW-1:0] u, v, w;

  hpt_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s_axis_tvalid),
    .x_i    ($signed(s_axis_tdata[15:0])),
    .y_i    ($signed(s_axis_tdata[31:16])),
    .coef_i (coef_q),
    .vld_o  (mac_vld),
    .u_o    (u),
    .v_o    (v),
    .w_o    (w)
  );

  // magnitudes, signs and early-out flags
  logic [hpt_pkg::AccW-1:0] nu, nv, dw;
  hpt_pkg::div_t            prep_d;
  hpt_pkg::div_t            dst [hpt_pkg::DivSteps+1];
  logic                     dvld [hpt_pkg::DivSteps+1];
  logic                     prep_vld_q;

  always_comb begin
    nu = u[hpt_pkg::AccW-1] ? hpt_pkg::AccW'(-u) : u;
    nv = v[hpt_pkg::AccW-1] ? hpt_pkg::AccW'(-v) : v;
    dw = w[hpt_pkg::AccW-1] ? hpt_pkg::AccW'(-w) : w;
    prep_d.den     = dw;
    prep_d.dz      = (w == '0);
    prep_d.cx.neg  = (u[hpt_pkg::AccW-1] ^ w[hpt_pkg::AccW-1]) && (nu != '0);
    prep_d.cy.neg  = (v[hpt_pkg::AccW-1] ^ w[hpt_pkg::AccW-1]) && (nv != '0);
    prep_d.cx.big  = {nu, 4'b0} >= {4'b0, dw};
    prep_d.cy.big  = {nv, 4'b0} >= {4'b0, dw};
    prep_d.cx.rem  = {nu[hpt_pkg::AccW-5:0], 4'b0};
    prep_d.cy.rem  = {nv[hpt_pkg::AccW-5:0], 4'b0};
    prep_d.cx.quot = '0;
    prep_d.cy.quot = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_vld_q <= 1'b0;
    end else if (adv) begin
      prep_vld_q <= mac_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dst[0] <= prep_d;
    end
  end

  assign dvld[0] = prep_vld_q;

  for (genvar g = 0; g < hpt_pkg::DivSteps; g++) begin : g_div
    hpt_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (dvld[g]),
      .st_i   (dst[g]),
      .vld_o  (dvld[g+1]),
      .st_o   (dst[g+1])
    );
  end

  logic [hpt_pkg::CoordW-1:0] ox, oy;
  hpt_pkg::status_e           ost;

  hpt_quant u_quant (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (dvld[hpt_pkg::DivSteps]),
    .st_i     (dst[hpt_pkg::DivSteps]),
    .vld_o    (m_axis_tvalid),
    .x_o      (ox),
    .y_o      (oy),
    .status_o (ost)
  );

  assign m_axis_tdata = {6'b0, ost, oy, ox};

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  a_divzero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ost == hpt_pkg::StatDivZero) |-> (ox == '0 && oy == '0))
    else $error("divide-by-zero result not zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output transfer changed");

endmodule

`default_nettype wire

// ----- hdl/hpt_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_mac
// Two-stage multiply and accumulate: products, then u, v and w sums.
// ----------------------------------------------------------------------------
module hpt_mac (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 en_i,
  input  wire logic                                 vld_i,
  input  wire logic signed [hpt_pkg::CoordW-1:0]    x_i,
  input  wire logic signed [hpt_pkg::CoordW-1:0]    y_i,
  input  wire hpt_pkg::coef_t                       coef_i,
  output logic                                      vld_o,
  output logic signed [hpt_pkg::AccW-1:0]           u_o,
  output logic signed [hpt_pkg::AccW-1:0]           v_o,
  output logic signed [hpt_pkg::AccW-1:0]           w_o
);

  localparam logic signed [hpt_pkg::AccW-1:0] OneW = 50'sh1000_0000_0000;

  logic signed [hpt_pkg::ProdW-1:0] prod_d [6];
  logic signed [hpt_pkg::ProdW-1:0] prod_q [6];
  logic signed [hpt_pkg::CoefW+11:0] tu_d, tu_q, tv_d, tv_q;
  logic signed [hpt_pkg::AccW-1:0] u_d, v_d, w_d, u_q, v_q, w_q;
  logic vld1_q, vld2_q;

  always_comb begin
    prod_d[0] = $signed(coef_i[hpt_pkg::RegH00]) * x_i;
    prod_d[1] = $signed(coef_i[hpt_pkg::RegH01]) * y_i;
    prod_d[2] = $signed(coef_i[hpt_pkg::RegH10]) * x_i;
    prod_d[3] = $signed(coef_i[hpt_pkg::RegH11]) * y_i;
    prod_d[4] = $signed(coef_i[hpt_pkg::RegH20]) * x_i;
    prod_d[5] = $signed(coef_i[hpt_pkg::RegH21]) * y_i;
    tu_d      = {coef_i[hpt_pkg::RegH02], 12'b0};
    tv_d      = {coef_i[hpt_pkg::RegH12], 12'b0};
  end

  always_comb begin
    u_d = hpt_pkg::AccW'(prod_q[0]) + hpt_pkg::AccW'(prod_q[1]) + hpt_pkg::AccW'(tu_q);
    v_d = hpt_pkg::AccW'(prod_q[2]) + hpt_pkg::AccW'(prod_q[3]) + hpt_pkg::AccW'(tv_q);
    w_d = hpt_pkg::AccW'(prod_q[4]) + hpt_pkg::AccW'(prod_q[5]) + OneW;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      tu_q   <= tu_d;
      tv_q   <= tv_d;
      u_q    <= u_d;
      v_q    <= v_d;
      w_q    <= w_d;
    end
  end

  assign vld_o = vld2_q;
  assign u_o   = u_q;
  assign v_o   = v_q;
  assign w_o   = w_q;

endmodule

`default_nettype wire

// ----- hdl/hpt_div_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_div_step
// One registered restoring-division step for both coordinates.
// ----------------------------------------------------------------------------
module hpt_div_step (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire hpt_pkg::div_t st_i,
  output logic               vld_o,
  output hpt_pkg::div_t      st_o
);

  function automatic hpt_pkg::chan_t step(hpt_pkg::chan_t c, logic [hpt_pkg::AccW-1:0] d);
    hpt_pkg::chan_t  r;
    logic [hpt_pkg::AccW:0] r2;
    r  = c;
    r2 = {c.rem, 1'b0};
    if (r2 >= {1'b0, d}) begin
      r2     = r2 - {1'b0, d};
      r.quot = {c.quot[hpt_pkg::QuotW-2:0], 1'b1};
    end else begin
      r.quot = {c.quot[hpt_pkg::QuotW-2:0], 1'b0};
    end
    r.rem = r2[hpt_pkg::AccW-1:0];
    return r;
  endfunction

  hpt_pkg::div_t st_d, st_q;
  logic          vld_q;

  always_comb begin
    st_d    = st_i;
    st_d.cx = step(st_i.cx, st_i.den);
    st_d.cy = step(st_i.cy, st_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign vld_o = vld_q;
  assign st_o  = st_q;

endmodule

`default_nettype wire

// ----- hdl/hpt_quant.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hpt_quant
// Rounding, saturation and status; holds the output register.
// ----------------------------------------------------------------------------
module hpt_quant (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              vld_i,
  input  wire hpt_pkg::div_t                     st_i,
  output logic                                   vld_o,
  output logic [hpt_pkg::CoordW-1:0]             x_o,
  output logic [hpt_pkg::CoordW-1:0]             y_o,
  output hpt_pkg::status_e                       status_o
);

  typedef struct packed {
    logic [hpt_pkg::CoordW-1:0] val;
    logic                       sat;
  } qres_t;

  function automatic qres_t fin(hpt_pkg::chan_t c, logic [hpt_pkg::AccW-1:0] d);
    qres_t                  r;
    logic [hpt_pkg::AccW:0] r2;
    logic [hpt_pkg::QuotW:0] m;
    logic [hpt_pkg::QuotW:0] lim;
    r2  = {c.rem, 1'b0};
    m   = {1'b0, c.quot} + ((r2 >= {1'b0, d}) ? 17'd1 : 17'd0);
    lim = c.neg ? 17'd32768 : 17'd32767;
    r.sat = c.big || (m > lim);
    if (r.sat) begin
      m = lim;
    end
    r.val = c.neg ? hpt_pkg::CoordW'(17'd0 - m) : m[hpt_pkg::CoordW-1:0];
    return r;
  endfunction

  qres_t             qx, qy;
  logic [hpt_pkg::CoordW-1:0] x_d, y_d, x_q, y_q;
  hpt_pkg::status_e  st_d, st_q;
  logic              vld_q;

  always_comb begin
    qx = fin(st_i.cx, st_i.den);
    qy = fin(st_i.cy, st_i.den);
    if (st_i.dz) begin
      x_d  = '0;
      y_d  = '0;
      st_d = hpt_pkg::StatDivZero;
    end else begin
      x_d  = qx.val;
      y_d  = qy.val;
      st_d = (qx.sat || qy.sat) ? hpt_pkg::StatSat : hpt_pkg::StatOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_d;
      y_q  <= y_d;
      st_q <= st_d;
    end
  end

  assign vld_o    = vld_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign status_o = st_q;

endmodule

`default_nettype wire
